@@ hw/rtl/dur_pkg.sv @@
// Shared types and constants for the dual UART register block.
package dur_pkg;

    // Transmit ring sizing, per UART.
    localparam int TX_RING_DEPTH = 64;
    localparam int RING_PTR_W    = (TX_RING_DEPTH > 1) ? $clog2(TX_RING_DEPTH) : 1;
    localparam int RING_CNT_W    = $clog2(TX_RING_DEPTH + 1);
    localparam int RING_ADDR_W   = $clog2(2 * TX_RING_DEPTH);

    // Address windows; each window is 1 KiB and aligned to its size.
    localparam logic [31:0] UART0_BASE = 32'h4001_3800;
    localparam logic [31:0] UART1_BASE = 32'h4000_4400;
    localparam int          WIN_LSB    = 10;

    // Register indices (byte offset divided by four).
    localparam logic [3:0] REG_CR1  = 4'd0;
    localparam logic [3:0] REG_CR2  = 4'd1;
    localparam logic [3:0] REG_CR3  = 4'd2;
    localparam logic [3:0] REG_BRR  = 4'd3;
    localparam logic [3:0] REG_GTPR = 4'd4;
    localparam logic [3:0] REG_RTOR = 4'd5;
    localparam logic [3:0] REG_RQR  = 4'd6;
    localparam logic [3:0] REG_ISR  = 4'd7;
    localparam logic [3:0] REG_ICR  = 4'd8;
    localparam logic [3:0] REG_RDR  = 4'd9;
    localparam logic [3:0] REG_TDR  = 4'd10;

    // Register memory address: unit bit above the register index.
    localparam int REG_ADDR_W = 5;

    // Data registers keep nine bits.
    localparam int DATA_W = 9;

    // Status flag positions in ISR and in the compact flag vector.
    localparam int ISR_RXNE_BIT = 5;
    localparam int ISR_TC_BIT   = 6;
    localparam int ISR_TXE_BIT  = 7;
    localparam int FLG_RXNE     = 0;
    localparam int FLG_TC       = 1;
    localparam int FLG_TXE      = 2;
    localparam logic [2:0] FLAGS_RESET = 3'b110;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_READ    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_POP     = 2'd2,
        REQ_DELIVER = 2'd3
    } req_kind_t;

    // Where the result of a request comes from, in the cycle after acceptance.
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_STATUS,
        SRC_IRQ,
        SRC_POP
    } res_src_t;

    // Register memory access for one request.
    typedef struct packed {
        logic                  rd_en;
        logic [REG_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [REG_ADDR_W-1:0] wr_addr;
        logic [31:0]           wr_data;
    } reg_req_t;

    // Transmit ring access for one request.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       unit;
        logic [7:0] data;
    } ring_req_t;

endpackage

@@ hw/rtl/dual_uart_register_block_unit.sv @@
// Top level of the dual UART register block: decode, status flags and result pipeline.
//
// The block takes one request per cycle when the output side is ready and returns
// exactly one result for each, through the first stage and the output register.
// Control, baud, guard, timeout, request and data registers of both UARTs sit in one
// register memory, and the transmit rings in a second memory; both have a registered
// read. All writes land at acceptance, so a request sees every earlier request's
// effect. Status flags and ring pointers are kept in flip-flops. No clearing pass
// follows reset.
module dual_uart_register_block_unit
    import dur_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Fields from bit 0: bus_address[31:0], write_data[31:0], unit_select, zero pad.
    input  logic [71:0] s_axis_tdata,
    // Fields from bit 0: req_type[1:0].
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: read_data[31:0], tx_byte[7:0], tx_byte_valid,
    // irq_first_uart, irq_second_uart, zero pad.
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    // Input fields.
    logic [31:0] bus_address;
    logic [31:0] write_data;
    logic        unit_select;
    req_kind_t   req_type;

    assign bus_address = s_axis_tdata[31:0];
    assign write_data  = s_axis_tdata[63:32];
    assign unit_select = s_axis_tdata[64];
    assign req_type    = req_kind_t'(s_axis_tuser);

    // Pipeline control.
    logic in_fire;
    logic s1_adv;
    logic s1_valid_reg;
    logic out_valid_reg;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Address decode.
    logic       hit0;
    logic       hit1;
    logic       addr_unit;
    logic [3:0] reg_idx;
    logic       reg_ok;

    always_comb
    begin
        hit0      = bus_address[31:WIN_LSB] == UART0_BASE[31:WIN_LSB];
        hit1      = bus_address[31:WIN_LSB] == UART1_BASE[31:WIN_LSB];
        addr_unit = hit1;
        reg_idx   = bus_address[5:2];
        reg_ok    = (hit0 || hit1) && (bus_address[WIN_LSB-1:6] == '0)
                    && (bus_address[1:0] == 2'b00) && (reg_idx <= REG_TDR);
    end

    // Status flags per UART: RXNE, TC, TXE.
    logic [2:0] flags_reg  [2];
    logic [2:0] flags_next [2];

    // Request decode: memory accesses, ring access, flag updates, result source.
    reg_req_t  reg_req;
    ring_req_t ring_req;
    res_src_t  src_next;
    logic      unit_next;

    always_comb
    begin
        reg_req       = '0;
        ring_req      = '0;
        src_next      = SRC_ZERO;
        unit_next     = addr_unit;
        flags_next[0] = flags_reg[0];
        flags_next[1] = flags_reg[1];
        ring_req.unit = unit_select;
        ring_req.data = write_data[7:0];
        if (in_fire)
        begin
            unique case (req_type)
                REQ_READ:
                begin
                    if (reg_ok)
                    begin
                        priority if (reg_idx == REG_ISR)
                        begin
                            src_next = SRC_STATUS;
                        end
                        else if (reg_idx == REG_ICR)
                        begin
                            src_next = SRC_ZERO;
                        end
                        else
                        begin
                            src_next        = SRC_MEM;
                            reg_req.rd_en   = 1'b1;
                            reg_req.rd_addr = {addr_unit, reg_idx};
                            if (reg_idx == REG_RDR)
                            begin
                                flags_next[addr_unit][FLG_RXNE] = 1'b0;
                            end
                        end
                    end
                end
                REQ_WRITE:
                begin
                    if (reg_ok)
                    begin
                        priority if (reg_idx <= REG_RQR)
                        begin
                            reg_req.wr_en   = 1'b1;
                            reg_req.wr_addr = {addr_unit, reg_idx};
                            reg_req.wr_data = write_data;
                        end
                        else if (reg_idx == REG_ICR)
                        begin
                            flags_next[addr_unit] = flags_reg[addr_unit] &
                                ~{write_data[ISR_TXE_BIT], write_data[ISR_TC_BIT],
                                  write_data[ISR_RXNE_BIT]};
                        end
                        else if (reg_idx == REG_TDR)
                        begin
                            reg_req.wr_en   = 1'b1;
                            reg_req.wr_addr = {addr_unit, REG_TDR};
                            reg_req.wr_data = {{(32-DATA_W){1'b0}}, write_data[DATA_W-1:0]};
                            reg_req.rd_en   = 1'b1;
                            reg_req.rd_addr = {addr_unit, REG_CR1};
                            ring_req.push   = 1'b1;
                            ring_req.unit   = addr_unit;
                            flags_next[addr_unit][FLG_TXE] = 1'b1;
                            flags_next[addr_unit][FLG_TC]  = 1'b1;
                            src_next        = SRC_IRQ;
                        end
                        else
                        begin
                            // ISR and RDR are read only.
                            src_next = SRC_ZERO;
                        end
                    end
                end
                REQ_POP:
                begin
                    ring_req.pop = 1'b1;
                    src_next     = SRC_POP;
                end
                REQ_DELIVER:
                begin
                    reg_req.wr_en   = 1'b1;
                    reg_req.wr_addr = {unit_select, REG_RDR};
                    reg_req.wr_data = {{(32-DATA_W){1'b0}}, write_data[DATA_W-1:0]};
                    flags_next[unit_select][FLG_RXNE] = 1'b1;
                end
                default:
                begin
                    src_next = SRC_ZERO;
                end
            endcase
        end
    end

    // Storage.
    logic [31:0] mem_rd_data;
    logic [7:0]  pop_byte;
    logic        pop_hit;

    dur_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (reg_req),
        .rd_data (mem_rd_data)
    );

    dur_tx_ring u_tx_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ring_req),
        .pop_byte (pop_byte),
        .pop_hit  (pop_hit)
    );

    // First stage: what the result is made of, captured at acceptance.
    res_src_t   s1_src_reg;
    logic       s1_unit_reg;
    logic [2:0] s1_flags_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_src_reg   <= src_next;
            s1_unit_reg  <= unit_next;
            s1_flags_reg <= flags_reg[addr_unit];
        end
    end

    // Control registers: flags and stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg[0]  <= FLAGS_RESET;
            flags_reg[1]  <= FLAGS_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg[0] <= flags_next[0];
            flags_reg[1] <= flags_next[1];
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result assembly from the memory read data, the ring read data and the captured flags.
    logic [31:0] res_read;
    logic [7:0]  res_byte;
    logic        res_byte_valid;
    logic        res_irq;
    logic [47:0] res_word;

    always_comb
    begin
        res_read       = 32'd0;
        res_byte       = 8'd0;
        res_byte_valid = 1'b0;
        res_irq        = 1'b0;
        unique case (s1_src_reg)
            SRC_MEM:
            begin
                res_read = mem_rd_data;
            end
            SRC_STATUS:
            begin
                res_read[ISR_RXNE_BIT] = s1_flags_reg[FLG_RXNE];
                res_read[ISR_TC_BIT]   = s1_flags_reg[FLG_TC];
                res_read[ISR_TXE_BIT]  = s1_flags_reg[FLG_TXE];
            end
            SRC_IRQ:
            begin
                res_irq = mem_rd_data[ISR_TXE_BIT] || mem_rd_data[ISR_TC_BIT];
            end
            SRC_POP:
            begin
                res_byte       = pop_byte;
                res_byte_valid = pop_hit;
            end
            default:
            begin
                res_read = 32'd0;
            end
        endcase
        res_word = {5'd0, res_irq && s1_unit_reg, res_irq && !s1_unit_reg,
                    res_byte_valid, res_byte, res_read};
    end

    // Output register.
    logic [47:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= res_word;
        end
    end

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule

@@ hw/rtl/dur_regfile.sv @@
// Register memory for both UARTs, with per-entry valid bits for the reset value.
module dur_regfile
    import dur_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  reg_req_t    req,
    output logic [31:0] rd_data
);

    localparam int ENTRIES = 2 ** REG_ADDR_W;

    logic [31:0]        mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        rd_raw_reg;
    logic               rd_valid_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem[req.rd_addr];
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : 32'd0;

endmodule

@@ hw/rtl/dur_tx_ring.sv @@
// Transmit byte rings for both UARTs in one memory, with head, tail and fill count.
module dur_tx_ring
    import dur_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ring_req_t  req,
    output logic [7:0] pop_byte,
    output logic       pop_hit
);

    localparam logic [RING_PTR_W-1:0] PTR_LAST  = RING_PTR_W'(TX_RING_DEPTH - 1);
    localparam logic [RING_CNT_W-1:0] CNT_FULL  = RING_CNT_W'(TX_RING_DEPTH);
    localparam logic [RING_ADDR_W-1:0] UNIT_OFS = RING_ADDR_W'(TX_RING_DEPTH);

    logic [7:0]            mem [2 * TX_RING_DEPTH];
    logic [RING_PTR_W-1:0] head_reg  [2];
    logic [RING_PTR_W-1:0] tail_reg  [2];
    logic [RING_CNT_W-1:0] count_reg [2];
    logic [7:0]            pop_byte_reg;
    logic                  pop_hit_reg;

    logic [RING_PTR_W-1:0]  head_cur;
    logic [RING_PTR_W-1:0]  tail_cur;
    logic [RING_CNT_W-1:0]  count_cur;
    logic                   do_push;
    logic                   do_pop;
    logic [RING_ADDR_W-1:0] push_addr;
    logic [RING_ADDR_W-1:0] pop_addr;

    // Pointer selection and full / empty checks for the addressed UART.
    always_comb
    begin
        head_cur  = head_reg[req.unit];
        tail_cur  = tail_reg[req.unit];
        count_cur = count_reg[req.unit];
        do_push   = req.push && (count_cur != CNT_FULL);
        do_pop    = req.pop && (count_cur != '0);
        push_addr = (req.unit ? UNIT_OFS : '0) + RING_ADDR_W'(head_cur);
        pop_addr  = (req.unit ? UNIT_OFS : '0) + RING_ADDR_W'(tail_cur);
    end

    // Byte storage: write on push, registered read on pop.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[push_addr] <= req.data;
        end
        if (req.pop)
        begin
            pop_byte_reg <= mem[pop_addr];
        end
    end

    // Ring pointers and the hit flag that travels with the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            tail_reg[0]  <= '0;
            tail_reg[1]  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            pop_hit_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                head_reg[req.unit]  <= (head_cur == PTR_LAST) ? '0 : head_cur + 1'b1;
                count_reg[req.unit] <= count_cur + 1'b1;
            end
            if (do_pop)
            begin
                tail_reg[req.unit]  <= (tail_cur == PTR_LAST) ? '0 : tail_cur + 1'b1;
                count_reg[req.unit] <= count_cur - 1'b1;
            end
            if (req.pop)
            begin
                pop_hit_reg <= do_pop;
            end
        end
    end

    assign pop_byte = pop_hit_reg ? pop_byte_reg : 8'd0;
    assign pop_hit  = pop_hit_reg;

endmodule
